@@ src/cch_pkg.sv @@
// ----------------------------------------------------------------------------
// cch_pkg
// Types and constants of the CJK character histogram core.
// ----------------------------------------------------------------------------
package cch_pkg;

  localparam int unsigned SLOT_W = 18;  // internal slot index, room for every mapped slot
  localparam int unsigned CP_W   = 21;  // gathered code point bits

  // word function codes
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

  // counted ranges and their first dense slot
  localparam logic [CP_W-1:0] CP_LING   = 21'h03007;
  localparam logic [CP_W-1:0] EXTA_LO   = 21'h03400;
  localparam logic [CP_W-1:0] EXTA_HI   = 21'h04DBF;
  localparam logic [CP_W-1:0] URO_LO    = 21'h04E00;
  localparam logic [CP_W-1:0] URO_HI    = 21'h09FFF;
  localparam logic [CP_W-1:0] COMPAT_LO = 21'h0F900;
  localparam logic [CP_W-1:0] COMPAT_HI = 21'h0FAFF;
  localparam logic [CP_W-1:0] EXTB_LO   = 21'h20000;
  localparam logic [CP_W-1:0] EXTB_HI   = 21'h2A6DF;
  localparam logic [CP_W-1:0] EXTC_LO   = 21'h2A700;
  localparam logic [CP_W-1:0] EXTC_HI   = 21'h2EBEF;
  localparam logic [CP_W-1:0] EXTG_LO   = 21'h30000;
  localparam logic [CP_W-1:0] EXTG_HI   = 21'h323AF;

  localparam logic [SLOT_W-1:0] EXTA_BASE   = 18'd1;
  localparam logic [SLOT_W-1:0] URO_BASE    = 18'd6593;
  localparam logic [SLOT_W-1:0] COMPAT_BASE = 18'd27585;
  localparam logic [SLOT_W-1:0] EXTB_BASE   = 18'd28097;
  localparam logic [SLOT_W-1:0] EXTC_BASE   = 18'd70817;
  localparam logic [SLOT_W-1:0] EXTG_BASE   = 18'd88465;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [16:0] read_slot;
  } in_t;

  typedef struct packed {
    logic        from_read;
    logic [17:0] code_point;
    logic [16:0] slot;
    logic [31:0] char_count;
  } out_t;

endpackage

@@ src/cjk_char_histogram_core.sv @@
// ----------------------------------------------------------------------------
// cjk_char_histogram_core
// UTF-8 decoder with a per-character histogram of CJK ideographs.
// ----------------------------------------------------------------------------
// Input channel: one word per cycle while in_stall_o is low. func = text
// carries one UTF-8 byte; func = read asks for the count of slot read_slot.
// A finished 3- or 4-byte character in a counted range bumps its slot
// counter (saturating) and produces one output word with code point, slot
// and new count. A read always produces one output word. Other bytes
// produce nothing. Throughput: one input word per cycle, sustained while
// the input is not stalled, including repeated hits on the same slot. A
// result reaches the output register through the mapping and memory read
// stage and the update stage. The counters live in one SLOTS-entry memory
// with a registered read; the last write is forwarded into the update stage.
// Reset: the decoder returns to idle and a clearing pass zeroes the counter
// memory, one entry per cycle; in_stall_o stays high until the pass ends.
// Stall: the output register holds its word while out_stall_i is high;
// words that cause no result keep flowing, and after the clearing pass the
// input stalls only when a result is blocked behind the output register.
// ----------------------------------------------------------------------------
module cjk_char_histogram_core #(
  parameter int unsigned SLOTS       = 131072,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cch_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cch_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
  localparam logic [cch_pkg::SLOT_W:0] SLOT_LIMIT = (cch_pkg::SLOT_W + 1)'(SLOTS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // --------------------------------------------------------------------------
  // clearing pass
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_q, clr_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == LAST_ADDR) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  logic adv, accept, s2_blocked, s2_emit;
  logic out_valid_q;

  // S2 registers (declared early for control)
  logic                      s2_valid_q, s2_read_q, s2_hit_q;
  logic [17:0]               s2_cp_q;
  logic [cch_pkg::SLOT_W-1:0] s2_slot_q;

  assign s2_emit    = s2_valid_q && (s2_read_q || s2_hit_q);
  assign s2_blocked = s2_emit && out_valid_q && out_stall_i;
  assign adv        = !s2_blocked;
  assign in_stall_o = clearing_q || s2_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // UTF-8 decoder
  logic [1:0]              bytes_left_q, bytes_left_d;
  logic [2:0]              seq_len_q, seq_len_d;
  logic [cch_pkg::CP_W-1:0] gath_q, gath_d, gath_next;
  logic                    done;
  logic [7:0]              b;

  assign b         = in_data_i.data_byte;
  assign gath_next = {gath_q[cch_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    bytes_left_d = bytes_left_q;
    seq_len_d    = seq_len_q;
    gath_d       = gath_q;
    done         = 1'b0;
    if (accept && in_data_i.func == cch_pkg::FUNC_TEXT) begin
      if (b == cch_pkg::BYTE_NEWLINE) begin
        // drop any unfinished sequence
        bytes_left_d = 2'd0;
        seq_len_d    = 3'd1;
        gath_d       = '0;
      end else if (bytes_left_q == 2'd0) begin
        case (b[7:3]) inside
          [5'b11000:5'b11011]: begin
            seq_len_d = 3'd2; bytes_left_d = 2'd1; gath_d = cch_pkg::CP_W'(b[4:0]);
          end
          [5'b11100:5'b11101]: begin
            seq_len_d = 3'd3; bytes_left_d = 2'd2; gath_d = cch_pkg::CP_W'(b[3:0]);
          end
          5'b11110: begin
            seq_len_d = 3'd4; bytes_left_d = 2'd3; gath_d = cch_pkg::CP_W'(b[2:0]);
          end
          default: begin
            seq_len_d = 3'd1; gath_d = '0;
          end
        endcase
      end else begin
        gath_d       = gath_next;
        bytes_left_d = bytes_left_q - 2'd1;
        if (bytes_left_q == 2'd1) begin
          done      = 1'b1;
          seq_len_d = 3'd1;
          gath_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      seq_len_q    <= 3'd1;
      gath_q       <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      seq_len_q    <= seq_len_d;
      gath_q       <= gath_d;
    end
  end

  // --------------------------------------------------------------------------
  // S1: finished character or read, slot mapping, memory read
  logic                      s1_valid_q, s1_read_q, s1_len3_q, s1_len4_q;
  logic [16:0]               s1_rslot_q;
  logic [cch_pkg::CP_W-1:0]  s1_cp_q;
  logic                      s1_load;

  assign s1_load = accept && ((in_data_i.func == cch_pkg::FUNC_READ) ||
                              (done && (seq_len_q == 3'd3 || seq_len_q == 3'd4)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_load) begin
      s1_read_q  <= (in_data_i.func == cch_pkg::FUNC_READ);
      s1_rslot_q <= in_data_i.read_slot;
      s1_cp_q    <= gath_next;
      s1_len3_q  <= (seq_len_q == 3'd3);
      s1_len4_q  <= (seq_len_q == 3'd4);
    end
  end

  logic                       map_hit, s1_hit;
  logic [cch_pkg::SLOT_W-1:0] map_slot, s1_slot;

  always_comb begin
    map_hit  = 1'b0;
    map_slot = '0;
    if (s1_len3_q) begin
      if (s1_cp_q == cch_pkg::CP_LING) begin
        map_hit = 1'b1;
      end else if (s1_cp_q >= cch_pkg::EXTA_LO && s1_cp_q <= cch_pkg::EXTA_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::EXTA_LO) + cch_pkg::EXTA_BASE;
      end else if (s1_cp_q >= cch_pkg::URO_LO && s1_cp_q <= cch_pkg::URO_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::URO_LO) + cch_pkg::URO_BASE;
      end else if (s1_cp_q >= cch_pkg::COMPAT_LO && s1_cp_q <= cch_pkg::COMPAT_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::COMPAT_LO) + cch_pkg::COMPAT_BASE;
      end
    end else if (s1_len4_q) begin
      if (s1_cp_q >= cch_pkg::EXTB_LO && s1_cp_q <= cch_pkg::EXTB_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::EXTB_LO) + cch_pkg::EXTB_BASE;
      end else if (s1_cp_q >= cch_pkg::EXTC_LO && s1_cp_q <= cch_pkg::EXTC_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::EXTC_LO) + cch_pkg::EXTC_BASE;
      end else if (s1_cp_q >= cch_pkg::EXTG_LO && s1_cp_q <= cch_pkg::EXTG_HI) begin
        map_hit  = 1'b1;
        map_slot = cch_pkg::SLOT_W'(s1_cp_q - cch_pkg::EXTG_LO) + cch_pkg::EXTG_BASE;
      end
    end
  end

  assign s1_slot = s1_read_q ? cch_pkg::SLOT_W'(s1_rslot_q) : map_slot;
  assign s1_hit  = (s1_read_q || map_hit) &&
                   ((cch_pkg::SLOT_W + 1)'(s1_slot) < SLOT_LIMIT);

  // --------------------------------------------------------------------------
  // counter memory
  logic [COUNT_WIDTH-1:0] mem [SLOTS];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   mem_re, mem_we, s2_wr;
  logic [AW-1:0]          mem_waddr, s2_addr;
  logic [COUNT_WIDTH-1:0] mem_wdata, s2_old, s2_inc;

  assign mem_re    = adv && s1_valid_q && s1_hit;
  assign s2_addr   = s2_slot_q[AW-1:0];
  assign s2_wr     = adv && s2_valid_q && s2_hit_q && !s2_read_q;
  assign mem_we    = clearing_q || s2_wr;
  assign mem_waddr = clearing_q ? clr_q : s2_addr;
  assign mem_wdata = clearing_q ? '0 : s2_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[s1_slot[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // S2: forward last write, saturating increment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_read_q <= s1_read_q;
      s2_hit_q  <= s1_hit;
      s2_cp_q   <= s1_read_q ? '0 : s1_cp_q[17:0];
      s2_slot_q <= s1_slot;
    end
  end

  logic                   wr_valid_q;
  logic [AW-1:0]          wr_addr_q;
  logic [COUNT_WIDTH-1:0] wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else if (adv) begin
      wr_valid_q <= s2_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_wr) begin
      wr_addr_q <= s2_addr;
      wr_data_q <= s2_inc;
    end
  end

  assign s2_old = (wr_valid_q && wr_addr_q == s2_addr) ? wr_data_q : rd_q;
  assign s2_inc = (s2_old == COUNT_MAX) ? s2_old : s2_old + COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] s2_count;
  always_comb begin
    if (!s2_hit_q) begin
      s2_count = '0;
    end else if (s2_read_q) begin
      s2_count = s2_old;
    end else begin
      s2_count = s2_inc;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  logic          out_valid_d;
  cch_pkg::out_t out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && s2_emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_emit) begin
      out_q.from_read  <= s2_read_q;
      out_q.code_point <= s2_cp_q;
      out_q.slot       <= s2_slot_q[16:0];
      out_q.char_count <= 32'(s2_count);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> in_stall_o)
    else $error("word accepted during clearing pass");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clearing_q) |-> (s2_valid_q && s2_hit_q && !s2_read_q))
    else $error("counter write without a counted character");

  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !clearing_q) |=> wr_valid_q)
    else $error("forwarding register missed a write");

  a_block_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_blocked |-> (in_stall_o && !mem_re && !mem_we))
    else $error("pipeline moved while result blocked");

  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q != 2'd0) |-> (seq_len_q != 3'd1))
    else $error("sequence in progress with length one");

endmodule

@@ tb/tb_cjk_char_histogram_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cjk_char_histogram_core
// Self-checking regression of the UTF-8 CJK character histogram core.
// Drives text bytes and slot reads over the valid/stall input channel.
// A decoder and counter model in the bench predicts every output word, and
// each output word is compared field by field with the oldest prediction.
// Random gaps on both channels, a long output hold and full-rate bursts on
// hot characters exercise stalls and counter forwarding.
// ----------------------------------------------------------------------------
module tb_cjk_char_histogram_core;

  localparam int unsigned SLOTS          = 131072;
  localparam int unsigned COUNT_WIDTH    = 32;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned RANDOM_WORDS   = 470;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned END_CYCLES     = 16;
  localparam int unsigned HOT_N          = 4;
  // the clearing pass after reset is the longest quiet stretch of a good run
  localparam int unsigned WATCHDOG_LIMIT = 3 * SLOTS + 1000;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  cch_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  cch_pkg::out_t  out_data_o;

  // bench-side decoder and counter state
  logic [1:0]             dec_left = '0;
  logic [2:0]             dec_len  = 3'd1;
  logic [20:0]            dec_bits = '0;
  logic [COUNT_WIDTH-1:0] slot_counts [int unsigned];
  cch_pkg::out_t          pending_results [$];

  logic [20:0] hot_cp [HOT_N];
  bit          tx_gaps_on  = 1'b1;
  bit          rx_stall_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;

  cjk_char_histogram_core #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [COUNT_WIDTH-1:0] count_of(input int unsigned s);
    return slot_counts.exists(s) ? slot_counts[s] : '0;
  endfunction

  function automatic bit cjk_slot(input logic [20:0] cp, input int unsigned len,
                                  output int unsigned slot);
    slot = 0;
    if (len == 3) begin
      if (cp == cch_pkg::CP_LING) begin
        slot = 0;
        return 1'b1;
      end
      if (cp >= cch_pkg::EXTA_LO && cp <= cch_pkg::EXTA_HI) begin
        slot = 32'(cch_pkg::EXTA_BASE) + 32'(cp - cch_pkg::EXTA_LO);
        return 1'b1;
      end
      if (cp >= cch_pkg::URO_LO && cp <= cch_pkg::URO_HI) begin
        slot = 32'(cch_pkg::URO_BASE) + 32'(cp - cch_pkg::URO_LO);
        return 1'b1;
      end
      if (cp >= cch_pkg::COMPAT_LO && cp <= cch_pkg::COMPAT_HI) begin
        slot = 32'(cch_pkg::COMPAT_BASE) + 32'(cp - cch_pkg::COMPAT_LO);
        return 1'b1;
      end
    end else if (len == 4) begin
      if (cp >= cch_pkg::EXTB_LO && cp <= cch_pkg::EXTB_HI) begin
        slot = 32'(cch_pkg::EXTB_BASE) + 32'(cp - cch_pkg::EXTB_LO);
        return 1'b1;
      end
      if (cp >= cch_pkg::EXTC_LO && cp <= cch_pkg::EXTC_HI) begin
        slot = 32'(cch_pkg::EXTC_BASE) + 32'(cp - cch_pkg::EXTC_LO);
        return 1'b1;
      end
      if (cp >= cch_pkg::EXTG_LO && cp <= cch_pkg::EXTG_HI) begin
        slot = 32'(cch_pkg::EXTG_BASE) + 32'(cp - cch_pkg::EXTG_LO);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic decode_and_count(input cch_pkg::in_t w);
    cch_pkg::out_t res;
    logic [20:0]   cp;
    int unsigned   len;
    int unsigned   slot;
    res = '0;
    if (w.func == cch_pkg::FUNC_READ) begin
      res.from_read  = 1'b1;
      res.slot       = w.read_slot;
      res.char_count = (32'(w.read_slot) < SLOTS) ? 32'(count_of(32'(w.read_slot))) : '0;
      pending_results.push_back(res);
    end else if (w.data_byte == cch_pkg::BYTE_NEWLINE) begin
      dec_left = '0;
      dec_len  = 3'd1;
      dec_bits = '0;
    end else if (dec_left == 2'd0) begin
      if (w.data_byte >= 8'hC0 && w.data_byte <= 8'hDF) begin
        dec_len = 3'd2; dec_left = 2'd1; dec_bits = 21'(w.data_byte[4:0]);
      end else if (w.data_byte >= 8'hE0 && w.data_byte <= 8'hEF) begin
        dec_len = 3'd3; dec_left = 2'd2; dec_bits = 21'(w.data_byte[3:0]);
      end else if (w.data_byte >= 8'hF0 && w.data_byte <= 8'hF7) begin
        dec_len = 3'd4; dec_left = 2'd3; dec_bits = 21'(w.data_byte[2:0]);
      end else begin
        dec_len = 3'd1; dec_bits = '0;
      end
    end else begin
      // continuation: take the low six bits, unchecked
      dec_bits = {dec_bits[14:0], w.data_byte[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        cp       = dec_bits;
        len      = 32'(dec_len);
        dec_len  = 3'd1;
        dec_bits = '0;
        if (cjk_slot(cp, len, slot) && slot < SLOTS) begin
          if (count_of(slot) != '1) slot_counts[slot] = count_of(slot) + COUNT_WIDTH'(1);
          res.code_point = cp[17:0];
          res.slot       = 17'(slot);
          res.char_count = 32'(count_of(slot));
          pending_results.push_back(res);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [20:0] rand_between(input logic [20:0] lo, input logic [20:0] hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 21'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  function automatic logic [20:0] pick_cjk();
    case ($urandom_range(0, 6))
      0:       return cch_pkg::CP_LING;
      1:       return rand_between(cch_pkg::EXTA_LO, cch_pkg::EXTA_HI);
      2:       return rand_between(cch_pkg::URO_LO, cch_pkg::URO_HI);
      3:       return rand_between(cch_pkg::COMPAT_LO, cch_pkg::COMPAT_HI);
      4:       return rand_between(cch_pkg::EXTB_LO, cch_pkg::EXTB_HI);
      5:       return rand_between(cch_pkg::EXTC_LO, cch_pkg::EXTC_HI);
      default: return rand_between(cch_pkg::EXTG_LO, cch_pkg::EXTG_HI);
    endcase
  endfunction

  function automatic int unsigned cjk_len(input logic [20:0] cp);
    return (cp > 21'h0FFFF) ? 4 : 3;
  endfunction

  function automatic logic [7:0] cont_byte(input logic [5:0] bits, input bit clean);
    return {clean ? 2'b10 : 2'($urandom), bits};
  endfunction

  // Present one word and return at the edge that accepts it. Valid stays up
  // so that a back-to-back word follows without a bubble.
  task automatic send_word(input cch_pkg::in_t w);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    decode_and_count(w);
    words_sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    cch_pkg::in_t w;
    w.func      = cch_pkg::FUNC_TEXT;
    w.data_byte = b;
    w.read_slot = 17'($urandom);
    send_word(w);
  endtask

  task automatic send_read(input logic [16:0] s);
    cch_pkg::in_t w;
    w.func      = cch_pkg::FUNC_READ;
    w.data_byte = 8'($urandom);
    w.read_slot = s;
    send_word(w);
  endtask

  task automatic send_char(input logic [20:0] cp, input int unsigned len, input bit clean);
    case (len)
      1: send_text({1'b0, cp[6:0]});
      2: begin
        send_text({3'b110, cp[10:6]});
        send_text(cont_byte(cp[5:0], clean));
      end
      3: begin
        send_text({4'b1110, cp[15:12]});
        send_text(cont_byte(cp[11:6], clean));
        send_text(cont_byte(cp[5:0], clean));
      end
      default: begin
        send_text({5'b11110, cp[20:18]});
        send_text(cont_byte(cp[17:12], clean));
        send_text(cont_byte(cp[11:6], clean));
        send_text(cont_byte(cp[5:0], clean));
      end
    endcase
  endtask

  task automatic send_hot_read(input int unsigned idx);
    int unsigned s;
    void'(cjk_slot(hot_cp[idx], cjk_len(hot_cp[idx]), s));
    send_read(17'(s));
  endtask

  // Drop valid and hold off until every predicted word has come out.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_char(cch_pkg::CP_LING, 3, 1'b1);
    send_char(cch_pkg::EXTB_LO, 4, 1'b1);
    // BMP code point in a 4-byte form is not counted
    send_char(cch_pkg::CP_LING, 4, 1'b1);
    // newline drops the unfinished sequence
    send_text(8'hE4);
    send_text(8'hB8);
    send_text(cch_pkg::BYTE_NEWLINE);
    send_char(cch_pkg::URO_LO, 3, 1'b1);
    // read in the middle of a sequence leaves the decoder alone
    send_text(8'hE9);
    send_read(17'd0);
    send_text(8'hBF);
    send_text(8'hBF);
    send_char(21'h000E9, 2, 1'b1);
    send_text(8'h41);
    send_text(8'hFF);
    send_read('1);
    send_read(17'd0);
  endtask

  task automatic test_back_to_back_hits();
    int unsigned i;
    hot_cp[0] = cch_pkg::EXTG_HI;
    for (i = 1; i < HOT_N; i++) hot_cp[i] = pick_cjk();
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    repeat (10) send_char(hot_cp[0], cjk_len(hot_cp[0]), 1'b1);
    repeat (6) begin
      send_char(hot_cp[1], cjk_len(hot_cp[1]), 1'b1);
      send_char(hot_cp[2], cjk_len(hot_cp[2]), 1'b1);
    end
    send_hot_read(0);
    send_hot_read(1);
    send_hot_read(0);
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // Hold the output for a long stretch while reads keep coming, so the
  // core backs up and stalls its input.
  task automatic test_output_hold();
    rx_hold_req = 1'b1;
    while (rx_hold_req) @(posedge clk_i);
    tx_gaps_on = 1'b0;
    repeat (32) send_read(17'($urandom));
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_slot_reads();
    repeat (40) begin
      case ($urandom_range(0, 3))
        0:       send_read(17'($urandom));
        1:       send_hot_read($urandom_range(0, HOT_N - 1));
        2:       send_read('1);
        default: send_read(17'($urandom_range(0, 8)));
      endcase
    end
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned r;
    int unsigned n;
    int unsigned idx;
    bit          clean;
    logic [20:0] cp;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      // switch idling off and on in stretches
      if ($urandom_range(0, 39) == 0) tx_gaps_on = !tx_gaps_on;
      if ($urandom_range(0, 39) == 0) rx_stall_on = !rx_stall_on;
      r     = $urandom_range(0, 99);
      clean = ($urandom_range(0, 9) != 0);
      idx   = $urandom_range(0, HOT_N - 1);
      if (r < 30) begin
        hot_cp[idx] = ($urandom_range(0, 3) == 0) ? pick_cjk() : hot_cp[idx];
        cp = pick_cjk();
        send_char(cp, cjk_len(cp), clean);
      end else if (r < 50) begin
        send_char(hot_cp[idx], cjk_len(hot_cp[idx]), clean);
      end else if (r < 58) begin
        send_char(21'($urandom_range(0, 16'hFFFF)), 3, clean);
      end else if (r < 63) begin
        send_char(21'($urandom), 4, clean);
      end else if (r < 70) begin
        send_char(21'($urandom_range(0, 11'h7FF)), 2, clean);
      end else if (r < 78) begin
        send_text(8'($urandom_range(0, 8'h7F)));
      end else if (r < 86) begin
        send_text(8'($urandom));
      end else if (r < 92) begin
        // broken sequence: lead, too few continuations, then newline or noise
        n = $urandom_range(2, 4);
        case (n)
          2:       send_text({3'b110, 5'($urandom)});
          3:       send_text({4'b1110, 4'($urandom)});
          default: send_text({5'b11110, 3'($urandom)});
        endcase
        repeat ($urandom_range(0, n - 2)) send_text(cont_byte(6'($urandom), 1'b1));
        if ($urandom_range(0, 1) == 0) send_text(cch_pkg::BYTE_NEWLINE);
        else send_text(8'($urandom));
      end else if (r < 96) begin
        send_hot_read(idx);
      end else begin
        send_read(17'($urandom));
      end
    end
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  always @(posedge clk_i) begin : compare_results
    cch_pkg::out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word: slot 0x%0h count 0x%0h",
                                  out_data_o.slot, out_data_o.char_count));
      end else begin
        want = pending_results.pop_front();
        compare_field("from_read", 32'(want.from_read), 32'(out_data_o.from_read));
        compare_field("code_point", 32'(want.code_point), 32'(out_data_o.code_point));
        compare_field("slot", 32'(want.slot), 32'(out_data_o.slot));
        compare_field("char_count", want.char_count, out_data_o.char_count);
      end
    end
  end

  // Output stall: random runs, a long hold on request, or off for a stretch.
  initial begin : drive_out_stall
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else if (!rx_stall_on) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run_tests
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    wait_results_drained();
    test_back_to_back_hits();
    wait_results_drained();
    test_output_hold();
    wait_results_drained();
    test_slot_reads();
    test_random_stream();

    rx_stall_on = 1'b0;
    wait_results_drained();
    // let any stray word show up
    repeat (END_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/cch_pkg.sv
src/cjk_char_histogram_core.sv
tb/tb_cjk_char_histogram_core.sv
